### rtl/core/sst_pkg.sv
// shared types and codes for the scoped symbol table
package sst_pkg;

   localparam int NAME_W = 64;
   localparam int ATTR_W = 41;

   typedef enum logic [2:0] {
      OP_OPEN      = 3'd0,
      OP_CLOSE     = 3'd1,
      OP_INSERT    = 3'd2,
      OP_FIND_CUR  = 3'd3,
      OP_FIND_ALL  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_DUP      = 2'd1,
      ST_FULL     = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [63:0]        name;
      logic [7:0]         sym_type;
      logic signed [31:0] location;
      logic               is_var;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [7:0]         found_scope;
      logic [7:0]         found_type;
      logic signed [31:0] found_location;
      logic               found_is_var;
   } rsp_type;

endpackage

### rtl/core/scoped_symbol_table.sv
// scoped symbol table: scope stack plus a table swept one slot per cycle
// request to response: open, close to an empty stack and unused codes go straight
//   to the response; close to a non-empty stack first reads the new top of stack;
//   insert and find-current sweep the table, stopping early on a hit; find-all reads
//   each stack level in turn and sweeps the table for it, one slot compare per cycle
// throughput: one transfer at a time, req_stall high from accept until rsp taken,
//   next request taken the cycle after the response transfer
// the single table read port and one compare unit set the rate
// reset: valid bits cleared at once, stack holds root scope 0, no clearing pass
module scoped_symbol_table #(
   parameter int TABLE_DEPTH = 256,
   parameter int STACK_DEPTH = 16,
   parameter int SCOPE_BITS  = 8,
   parameter int NAME_CHARS  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sst_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sst_pkg::rsp_type   rsp_data
);
   localparam int TW = $clog2(TABLE_DEPTH);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [SCOPE_BITS-1:0] SCOPE_LIMIT = {SCOPE_BITS{1'b1}};

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_CMP  = 4'b0100,
      S_RSP  = 4'b1000
   } state_type;

   // table memory: key and attributes, read data registered
   logic [sst_pkg::NAME_W-1:0] mem_name [TABLE_DEPTH];
   logic [SCOPE_BITS-1:0]      mem_scope [TABLE_DEPTH];
   logic [sst_pkg::ATTR_W-1:0] mem_attr [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]     valid_ff;
   logic [SCOPE_BITS-1:0]      stack_mem [STACK_DEPTH];

   state_type state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [SCOPE_BITS-1:0]  cur_ff, cur_in, high_ff, high_in;
   sst_pkg::req_type       req_ff;
   logic [sst_pkg::NAME_W-1:0] key_ff;
   logic [TW:0]            idx_ff, idx_in;
   logic [CW-1:0]          lvl_ff, lvl_in;       // stack level being probed
   logic [SCOPE_BITS-1:0]  probe_ff, probe_in;   // scope being probed
   logic                   free_ok_ff, free_ok_in;
   logic [TW-1:0]          free_ff, free_in;
   logic [TW-1:0]          rd_idx_ff;
   logic                   rd_v_ff;
   logic [sst_pkg::NAME_W-1:0] rd_name_ff;
   logic [SCOPE_BITS-1:0]  rd_scope_ff;
   logic [sst_pkg::ATTR_W-1:0] rd_attr_ff;
   logic                   stack_rd_en;
   logic [SW-1:0]          stack_rd_addr;
   logic [SCOPE_BITS-1:0]  stack_q_ff;
   sst_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   wr_en;
   logic                   push_en;
   logic [sst_pkg::NAME_W-1:0] norm;
   logic                   hit;

   // lowercase and truncate at first zero byte or after NAME_CHARS bytes
   always_comb begin
      logic alive;
      logic [7:0] ch;
      norm = '0;
      alive = 1'b1;
      for (int i = 0; i < 8; i++) begin
         ch = req_data.name[8*i +: 8];
         if (ch == 8'd0 || i >= NAME_CHARS) alive = 1'b0;
         if (alive) begin
            if (ch >= 8'h41 && ch <= 8'h5a) ch = ch + 8'd32;
            norm[8*i +: 8] = ch;
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data  = rsp_ff;

   assign hit = rd_v_ff && rd_scope_ff == probe_ff && rd_name_ff == key_ff;

   // table read port, one slot per cycle
   always_ff @(posedge clock) begin
      rd_idx_ff   <= idx_ff[TW-1:0];
      rd_v_ff     <= valid_ff[idx_ff[TW-1:0]];
      rd_name_ff  <= mem_name[idx_ff[TW-1:0]];
      rd_scope_ff <= mem_scope[idx_ff[TW-1:0]];
      rd_attr_ff  <= mem_attr[idx_ff[TW-1:0]];
      if (wr_en) begin
         mem_name[free_ff]  <= key_ff;
         mem_scope[free_ff] <= cur_ff;
         mem_attr[free_ff]  <= {req_ff.is_var, req_ff.location, req_ff.sym_type};
      end
   end

   always_ff @(posedge clock) begin
      if (stack_rd_en) stack_q_ff <= stack_mem[stack_rd_addr];
      if (reset) stack_mem[0] <= '0;
      else if (push_en) stack_mem[count_ff[SW-1:0]] <= high_ff + 1'b1;
   end

   always_comb begin
      logic [CW-1:0] c1;
      state_in   = state_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      high_in    = high_ff;
      idx_in     = idx_ff;
      lvl_in     = lvl_ff;
      probe_in   = probe_ff;
      free_ok_in = free_ok_ff;
      free_in    = free_ff;
      rsp_in     = rsp_ff;
      wr_en      = 1'b0;
      push_en    = 1'b0;
      stack_rd_en   = 1'b0;
      stack_rd_addr = '0;
      c1 = count_ff - 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rsp_in = '0;
               rsp_in.status = sst_pkg::ST_DONE;
               rsp_in.found_scope = 8'(cur_ff);
               idx_in = '0;
               free_ok_in = 1'b0;
               probe_in = cur_ff;
               lvl_in = count_ff;
               state_in = S_RSP;
               unique case (req_data.op)
                  sst_pkg::OP_OPEN: begin
                     if (high_ff == SCOPE_LIMIT || count_ff == CW'(STACK_DEPTH)) begin
                        rsp_in.status = sst_pkg::ST_OVERFLOW;
                     end else begin
                        push_en = 1'b1;
                        high_in = high_ff + 1'b1;
                        cur_in = high_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                        rsp_in.found_scope = 8'(high_ff + 1'b1);
                     end
                  end
                  sst_pkg::OP_CLOSE: begin
                     // new top read from stack, cur updated in S_CMP
                     if (count_ff != '0) begin
                        count_in = c1;
                        if (c1 != '0) begin
                           stack_rd_en = 1'b1;
                           stack_rd_addr = SW'(c1 - 1'b1);
                           state_in = S_CMP;
                        end
                     end
                  end
                  sst_pkg::OP_INSERT, sst_pkg::OP_FIND_CUR: state_in = S_SCAN;
                  sst_pkg::OP_FIND_ALL: begin
                     if (count_ff != '0) begin
                        stack_rd_en = 1'b1;
                        stack_rd_addr = SW'(c1);
                        state_in = S_CMP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CMP: begin
            // stack read returned
            if (req_ff.op == sst_pkg::OP_CLOSE) begin
               cur_in = stack_q_ff;
               rsp_in.found_scope = 8'(stack_q_ff);
               state_in = S_RSP;
            end else begin
               probe_in = stack_q_ff;
               lvl_in = lvl_ff - 1'b1;
               idx_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // idx_ff issues reads; the compare of each slot follows in the next cycle
            if (idx_ff != '0 && hit) begin
               if (req_ff.op == sst_pkg::OP_INSERT) begin
                  rsp_in.status = sst_pkg::ST_DUP;
               end else begin
                  rsp_in.found = 1'b1;
                  rsp_in.found_scope = 8'(rd_scope_ff);
                  rsp_in.found_type = rd_attr_ff[7:0];
                  rsp_in.found_location = rd_attr_ff[39:8];
                  rsp_in.found_is_var = rd_attr_ff[40];
               end
               state_in = S_RSP;
            end else begin
               if (idx_ff != '0 && !rd_v_ff && !free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_in = rd_idx_ff;
               end
               if (idx_ff == (TW+1)'(TABLE_DEPTH)) begin
                  state_in = S_RSP;
                  if (req_ff.op == sst_pkg::OP_INSERT) begin
                     if (!free_ok_in) rsp_in.status = sst_pkg::ST_FULL;
                  end else if (req_ff.op == sst_pkg::OP_FIND_ALL && lvl_ff != '0) begin
                     stack_rd_en = 1'b1;
                     stack_rd_addr = SW'(lvl_ff - 1'b1);
                     state_in = S_CMP;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_RSP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // write of the chosen free slot happens when the insert response is taken
      if (state_ff == S_RSP && req_ff.op == sst_pkg::OP_INSERT
          && rsp_ff.status == sst_pkg::ST_DONE && free_ok_ff && !rsp_stall)
         wr_en = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= CW'(1);
         cur_ff   <= '0;
         high_ff  <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         high_ff  <= high_in;
         if (wr_en) valid_ff[free_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         req_ff <= req_data;
         key_ff <= norm;
      end
      idx_ff     <= idx_in;
      lvl_ff     <= lvl_in;
      probe_ff   <= probe_in;
      free_ok_ff <= free_ok_in;
      free_ff    <= free_in;
      rsp_ff     <= rsp_in;
   end

   // no new transfer while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accepted during response");
   // stack never exceeds its depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH)) else $error("stack overflow");
   // a held response stays unchanged
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)) else $error("rsp changed");
endmodule

### tb/scoped_symbol_table_tb.sv
// testbench for the scoped symbol table: directed and random operations checked by a scoreboard
module scoped_symbol_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS = 256;
   localparam int STACK_LEVELS = 16;
   localparam int SCOPE_MAX = 255;
   localparam int RANDOM_ITEMS = 450;
   // worst item is a find through 16 levels of a 256-slot sweep, plus both idle gaps,
   // for every transfer of the run
   localparam int CYCLE_LIMIT = 30_000_000;

   // symbol table predictor plus the queue of responses still owed by the block
   class symtab_scoreboard;
      bit            slot_used [TABLE_SLOTS];
      logic [63:0]   slot_name [TABLE_SLOTS];
      logic [7:0]    slot_scope [TABLE_SLOTS];
      logic [7:0]    slot_type [TABLE_SLOTS];
      logic [31:0]   slot_loc [TABLE_SLOTS];
      logic          slot_var [TABLE_SLOTS];
      logic [7:0]    scope_stack [STACK_LEVELS];
      int            depth;
      logic [7:0]    cur_scope;
      int            top_scope;
      int            used;
      int            fails;
      sst_pkg::rsp_type owed [$];

      function void clear();
         foreach (slot_used[i]) slot_used[i] = 0;
         scope_stack[0] = 0;
         depth = 1;
         cur_scope = 0;
         top_scope = 0;
         used = 0;
         fails = 0;
         owed.delete();
      endfunction

      // keep bytes up to the first zero, fold A-Z to lower case
      function logic [63:0] fold_name(logic [63:0] raw);
         logic [63:0] key;
         logic [7:0] ch;
         key = '0;
         for (int i = 0; i < 8; i++) begin
            ch = raw[8*i +: 8];
            if (ch == 8'd0) break;
            if (ch >= "A" && ch <= "Z") ch = ch + 8'd32;
            key[8*i +: 8] = ch;
         end
         return key;
      endfunction

      function int slot_of(logic [7:0] scope, logic [63:0] key);
         for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_used[i] && slot_scope[i] == scope && slot_name[i] == key) return i;
         return -1;
      endfunction

      // apply one accepted request and queue the response it must produce
      function void note_request(sst_pkg::req_type r);
         logic [63:0] key;
         sst_pkg::rsp_type exp;
         int hit;
         key = fold_name(r.name);
         hit = -1;
         exp = '0;
         exp.status = sst_pkg::ST_DONE;
         case (r.op)
            sst_pkg::OP_OPEN: begin
               if (top_scope >= SCOPE_MAX || depth >= STACK_LEVELS) begin
                  exp.status = sst_pkg::ST_OVERFLOW;
               end else begin
                  top_scope++;
                  cur_scope = top_scope[7:0];
                  scope_stack[depth] = cur_scope;
                  depth++;
               end
            end
            sst_pkg::OP_CLOSE: begin
               if (depth > 0) depth--;
               if (depth > 0) cur_scope = scope_stack[depth-1];
            end
            sst_pkg::OP_INSERT: begin
               if (slot_of(cur_scope, key) >= 0) begin
                  exp.status = sst_pkg::ST_DUP;
               end else begin
                  exp.status = sst_pkg::ST_FULL;
                  for (int i = 0; i < TABLE_SLOTS; i++) begin
                     if (!slot_used[i]) begin
                        slot_used[i] = 1;
                        slot_name[i] = key;
                        slot_scope[i] = cur_scope;
                        slot_type[i] = r.sym_type;
                        slot_loc[i] = r.location;
                        slot_var[i] = r.is_var;
                        used++;
                        exp.status = sst_pkg::ST_DONE;
                        break;
                     end
                  end
               end
            end
            sst_pkg::OP_FIND_CUR: hit = slot_of(cur_scope, key);
            sst_pkg::OP_FIND_ALL: begin
               for (int lvl = depth - 1; lvl >= 0 && hit < 0; lvl--)
                  hit = slot_of(scope_stack[lvl], key);
            end
            default: ;
         endcase
         if (hit >= 0) begin
            exp.found = 1;
            exp.found_scope = slot_scope[hit];
            exp.found_type = slot_type[hit];
            exp.found_location = slot_loc[hit];
            exp.found_is_var = slot_var[hit];
         end else begin
            exp.found_scope = cur_scope;
         end
         owed.push_back(exp);
      endfunction

      function void compare(string field, logic [63:0] exp, logic [63:0] got);
         if (exp !== got) begin
            $error("%s mismatch: expected %0h, got %0h", field, exp, got);
            fails++;
         end
      endfunction

      function void check_response(sst_pkg::rsp_type got);
         sst_pkg::rsp_type exp;
         if (owed.size() == 0) begin
            $error("response transfer with nothing outstanding: %0h", got);
            fails++;
            return;
         end
         exp = owed.pop_front();
         compare("status", exp.status, got.status);
         compare("found", exp.found, got.found);
         compare("found_scope", exp.found_scope, got.found_scope);
         compare("found_type", exp.found_type, got.found_type);
         compare("found_location", exp.found_location, got.found_location);
         compare("found_is_var", exp.found_is_var, got.found_is_var);
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   sst_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   sst_pkg::rsp_type rsp_data;

   symtab_scoreboard sb;
   bit      quiet = 0;   // when set both sides run with no idle cycles
   longint  cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   scoped_symbol_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // one request transfer: idle gap, then hold valid until the block takes it
   task automatic send(sst_pkg::req_type r);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   function automatic sst_pkg::req_type make_req(logic [2:0] op, logic [63:0] name);
      sst_pkg::req_type r;
      r.op = op;
      r.name = name;
      r.sym_type = 8'($urandom_range(0, 255));
      r.location = $urandom;
      r.is_var = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // names from a small pool so lookups hit, with random case and junk after the terminator
   function automatic logic [63:0] pool_name();
      logic [63:0] n;
      int k, len;
      logic [7:0] ch;
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      k = $urandom_range(0, 11);
      len = 1 + k % 8;
      n = '0;
      for (int i = 0; i < len; i++) begin
         ch = "a" + 8'((k + i) % 26);
         if ($urandom_range(0, 1)) ch = ch - 8'd32;
         n[8*i +: 8] = ch;
      end
      if (len < 7 && $urandom_range(0, 3) == 0)
         for (int i = len + 1; i < 8; i++) n[8*i +: 8] = 8'($urandom_range(0, 255));
      return n;
   endfunction

   // stop offering requests, then wait until every owed response is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.owed.size() != 0) @(posedge clock);
   endtask

   // response side: random stall before each transfer, checked at the rising edge
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 17);
         if (hold > 0) begin
            rsp_stall <= 1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
         @(negedge clock);
      end
   end

   initial begin
      sst_pkg::req_type r;
      int pick;
      logic [2:0] op;
      sb = new();
      sb.clear();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: shadowing, duplicates, case folding, empty stack, unused codes
      send(make_req(sst_pkg::OP_FIND_ALL, "x"));
      r = make_req(sst_pkg::OP_INSERT, "ooF");   // "Foo" with first char in low byte
      r.sym_type = 8'h00; r.location = 32'sh8000_0000; r.is_var = 0;
      send(r);
      send(make_req(sst_pkg::OP_INSERT, "OOF"));         // duplicate after case folding
      send(make_req(sst_pkg::OP_FIND_CUR, "oof"));
      send(make_req(sst_pkg::OP_OPEN, 0));
      r = make_req(sst_pkg::OP_INSERT, "oof");
      r.sym_type = 8'hff; r.location = 32'sh7fff_ffff; r.is_var = 1;
      send(r);                                  // shadows the root symbol
      send(make_req(sst_pkg::OP_FIND_ALL, "oof"));
      send(make_req(sst_pkg::OP_FIND_ALL, "ooF"));
      send(make_req(sst_pkg::OP_FIND_CUR, "zz"));
      // bytes after a zero byte are ignored
      send(make_req(sst_pkg::OP_INSERT, 64'hdead_beef_00_62_61));
      send(make_req(sst_pkg::OP_FIND_CUR, 64'h0000_0000_00_42_41));
      send(make_req(sst_pkg::OP_INSERT, 64'hffff_ffff_ffff_ffff));
      send(make_req(sst_pkg::OP_FIND_ALL, 64'hffff_ffff_ffff_ffff));
      send(make_req(sst_pkg::OP_INSERT, 64'd0));         // empty name is a legal key
      send(make_req(sst_pkg::OP_CLOSE, 0));
      send(make_req(sst_pkg::OP_FIND_ALL, "oof"));
      send(make_req(sst_pkg::OP_CLOSE, 0));              // root popped, scope kept
      send(make_req(sst_pkg::OP_CLOSE, 0));              // close on an empty stack
      send(make_req(sst_pkg::OP_FIND_ALL, "oof"));       // empty stack finds nothing
      send(make_req(sst_pkg::OP_FIND_CUR, "oof"));
      send(make_req(3'd5, {$urandom, $urandom}));
      send(make_req(3'd6, 0));
      send(make_req(3'd7, 64'hffff_ffff_ffff_ffff));
      send(make_req(sst_pkg::OP_OPEN, 0));               // open from an empty stack

      // random operations over a small name pool
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) drain();    // sender holds off until all is back
         pick = $urandom_range(0, 99);
         if (pick < 22) op = sst_pkg::OP_OPEN;
         else if (pick < 40) op = sst_pkg::OP_CLOSE;
         else if (pick < 66) op = sst_pkg::OP_INSERT;
         else if (pick < 80) op = sst_pkg::OP_FIND_CUR;
         else if (pick < 97) op = sst_pkg::OP_FIND_ALL;
         else op = 3'($urandom_range(5, 7));
         send(make_req(op, pool_name()));
      end
      quiet = 0;
      drain();

      // stack overflow, then run the scope numbers out
      repeat (STACK_LEVELS + 1) send(make_req(sst_pkg::OP_OPEN, 0));
      while (sb.top_scope < SCOPE_MAX) begin
         send(make_req(sst_pkg::OP_CLOSE, 0));
         send(make_req(sst_pkg::OP_OPEN, 0));
      end
      send(make_req(sst_pkg::OP_OPEN, 0));
      send(make_req(sst_pkg::OP_CLOSE, 0));

      // fill the table, then overfill it
      for (int n = 0; sb.used < TABLE_SLOTS; n++)
         send(make_req(sst_pkg::OP_INSERT,
                       {48'h0, 8'("a" + n % 26), 8'("A" + n / 26 % 26)}));
      repeat (3) send(make_req(sst_pkg::OP_INSERT, pool_name() ^ 64'h70));
      repeat (6) send(make_req(sst_pkg::OP_FIND_ALL, pool_name()));
      send(make_req(sst_pkg::OP_INSERT, sb.slot_name[0]));

      @(negedge clock);
      req_valid <= 0;
      drain();
      repeat (40) @(posedge clock);
      if (sb.fails == 0 && sb.owed.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/core/sst_pkg.sv
rtl/core/scoped_symbol_table.sv
tb/scoped_symbol_table_tb.sv
